// ----- rtl/udpb_pkg.sv -----
`default_nettype none

package udpb_pkg;

    localparam int COUNT_W = 11;
    localparam int SUM_W   = 27;
    localparam int ACC_W   = 28;
    localparam int IDX_W   = 6;
    localparam int STEP_W  = 4;

    localparam int HDR_BYTES   = 42;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [7:0]  BCAST_BYTE     = 8'hFF;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] IP_FIXED_SUM   = 16'h8511;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
    localparam logic [15:0] CSUM_ALL_ONES  = 16'hFFFF;
    localparam logic [STEP_W-1:0] SUM_STEPS_LAST = 4'd8;

    localparam logic [2:0] CFG_SOURCE_MAC  = 3'd0;
    localparam logic [2:0] CFG_SOURCE_IP   = 3'd1;
    localparam logic [2:0] CFG_DEST_IP     = 3'd2;
    localparam logic [2:0] CFG_SOURCE_PORT = 3'd3;
    localparam logic [2:0] CFG_DEST_PORT   = 3'd4;

    localparam logic [47:0] RST_SOURCE_MAC  = 48'd0;
    localparam logic [31:0] RST_SOURCE_IP   = 32'd0;
    localparam logic [31:0] RST_DEST_IP     = 32'd3232235917;
    localparam logic [15:0] RST_SOURCE_PORT = 16'd55555;
    localparam logic [15:0] RST_DEST_PORT   = 16'd3000;

    typedef struct packed {
        logic               too_long;
        logic [COUNT_W-1:0] len;
        logic [SUM_W-1:0]   sum;
        logic [15:0]        ident;
    } t_desc;

    typedef struct packed {
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/udpb_front.sv -----
`default_nettype none

module udpb_front #(
    parameter int MAX_PAYLOAD_BYTES = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_payload_byte,
    input  wire logic           i_final_byte,
    input  wire logic [15:0]    i_ident,
    output udpb_pkg::t_desc     o_desc,
    output logic                o_push
);

    localparam logic [udpb_pkg::COUNT_W-1:0] MaxLen =
        udpb_pkg::COUNT_W'(MAX_PAYLOAD_BYTES);
    localparam logic [udpb_pkg::COUNT_W-1:0] OverLen =
        udpb_pkg::COUNT_W'(MAX_PAYLOAD_BYTES + 1);

    logic [udpb_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [udpb_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]                   r_held, n_held;

    always_comb begin
        n_sum  = r_sum;
        n_cnt  = r_cnt;
        n_held = r_held;
        if (r_cnt < MaxLen) begin
            if (!r_cnt[0]) begin
                n_held = i_payload_byte;
                if (i_final_byte) begin
                    n_sum = r_sum + udpb_pkg::SUM_W'({i_payload_byte, 8'h00});
                end
            end else begin
                n_sum = r_sum + udpb_pkg::SUM_W'({r_held, i_payload_byte});
            end
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = OverLen;
        end
    end

    always_comb begin
        o_desc.too_long = (n_cnt > MaxLen);
        o_desc.len      = n_cnt;
        o_desc.sum      = n_sum;
        o_desc.ident    = i_ident;
        o_push          = i_accept && i_final_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            if (i_final_byte) begin
                r_sum  <= '0;
                r_cnt  <= '0;
                r_held <= '0;
            end else begin
                r_sum  <= n_sum;
                r_cnt  <= n_cnt;
                r_held <= n_held;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/udpb_queue.sv -----
`default_nettype none

module udpb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  udpb_pkg::t_desc     i_desc,
    output logic                o_full,
    output logic                o_empty,
    input  wire logic           i_pop,
    output udpb_pkg::t_desc     o_desc
);

    udpb_pkg::t_desc r_mem [udpb_pkg::QUEUE_DEPTH];

    logic [udpb_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [udpb_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [udpb_pkg::QPTR_W:0]   r_count;

    assign o_full  = (r_count == (udpb_pkg::QPTR_W + 1)'(udpb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/udpb_back.sv -----
`default_nettype none

module udpb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  udpb_pkg::t_cfg      i_cfg,
    input  wire logic           i_q_empty,
    input  udpb_pkg::t_desc     i_q_desc,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_header_byte,
    output logic                o_run_end,
    output logic                o_too_long
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SUM   = 6'b000010,
        ST_FOLD1 = 6'b000100,
        ST_FOLD2 = 6'b001000,
        ST_SEND  = 6'b010000,
        ST_ERR   = 6'b100000
    } t_state;

    t_state r_state;

    logic [udpb_pkg::COUNT_W-1:0] r_len;
    logic [15:0]                  r_ident;
    logic [udpb_pkg::ACC_W-1:0]   r_udp_acc;
    logic [udpb_pkg::ACC_W-1:0]   r_ip_acc;
    logic [udpb_pkg::STEP_W-1:0]  r_step;
    logic [udpb_pkg::IDX_W-1:0]   r_idx;

    logic       r_out_valid;
    logic [7:0] r_header_byte;
    logic       r_run_end;
    logic       r_too_long;

    logic        out_free;
    logic        out_load;
    logic [15:0] udp_len;
    logic [15:0] tot_len;
    logic [15:0] udp_term;
    logic [15:0] ip_term;
    logic [15:0] udp_ck;
    logic [15:0] ip_ck;
    logic [7:0]  hdr_byte;
    logic        last_byte;

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = ((r_state == ST_SEND) || (r_state == ST_ERR)) && out_free;
    assign udp_len  = 16'(r_len) + udpb_pkg::UDP_HDR_LEN;
    assign tot_len  = 16'(r_len) + udpb_pkg::IP_UDP_HDR_LEN;
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign last_byte = (r_idx == udpb_pkg::IDX_W'(udpb_pkg::HDR_BYTES - 1));

    always_comb begin
        case (r_step)
            4'd0:    udp_term = i_cfg.source_ip[31:16];
            4'd1:    udp_term = i_cfg.source_ip[15:0];
            4'd2:    udp_term = i_cfg.dest_ip[31:16];
            4'd3:    udp_term = i_cfg.dest_ip[15:0];
            4'd4:    udp_term = 16'(udpb_pkg::IP_PROTO_UDP);
            4'd5:    udp_term = udp_len;
            4'd6:    udp_term = i_cfg.source_port;
            4'd7:    udp_term = i_cfg.dest_port;
            4'd8:    udp_term = udp_len;
            default: udp_term = '0;
        endcase
        case (r_step)
            4'd0:    ip_term = i_cfg.source_ip[31:16];
            4'd1:    ip_term = i_cfg.source_ip[15:0];
            4'd2:    ip_term = i_cfg.dest_ip[31:16];
            4'd3:    ip_term = i_cfg.dest_ip[15:0];
            4'd4:    ip_term = tot_len;
            4'd5:    ip_term = r_ident;
            default: ip_term = '0;
        endcase
    end

    always_comb begin
        udp_ck = ~r_udp_acc[15:0];
        if (udp_ck == '0) begin
            udp_ck = udpb_pkg::CSUM_ALL_ONES;
        end
        ip_ck = ~r_ip_acc[15:0];
    end

    always_comb begin
        case (r_idx) inside
            [6'd0:6'd5]: hdr_byte = udpb_pkg::BCAST_BYTE;
            6'd6:    hdr_byte = i_cfg.source_mac[47:40];
            6'd7:    hdr_byte = i_cfg.source_mac[39:32];
            6'd8:    hdr_byte = i_cfg.source_mac[31:24];
            6'd9:    hdr_byte = i_cfg.source_mac[23:16];
            6'd10:   hdr_byte = i_cfg.source_mac[15:8];
            6'd11:   hdr_byte = i_cfg.source_mac[7:0];
            6'd12:   hdr_byte = udpb_pkg::ETHERTYPE_IPV4[15:8];
            6'd13:   hdr_byte = udpb_pkg::ETHERTYPE_IPV4[7:0];
            6'd14:   hdr_byte = udpb_pkg::IP_VER_IHL;
            6'd16:   hdr_byte = tot_len[15:8];
            6'd17:   hdr_byte = tot_len[7:0];
            6'd18:   hdr_byte = r_ident[15:8];
            6'd19:   hdr_byte = r_ident[7:0];
            6'd22:   hdr_byte = udpb_pkg::IP_TTL;
            6'd23:   hdr_byte = udpb_pkg::IP_PROTO_UDP;
            6'd24:   hdr_byte = ip_ck[15:8];
            6'd25:   hdr_byte = ip_ck[7:0];
            6'd26:   hdr_byte = i_cfg.source_ip[31:24];
            6'd27:   hdr_byte = i_cfg.source_ip[23:16];
            6'd28:   hdr_byte = i_cfg.source_ip[15:8];
            6'd29:   hdr_byte = i_cfg.source_ip[7:0];
            6'd30:   hdr_byte = i_cfg.dest_ip[31:24];
            6'd31:   hdr_byte = i_cfg.dest_ip[23:16];
            6'd32:   hdr_byte = i_cfg.dest_ip[15:8];
            6'd33:   hdr_byte = i_cfg.dest_ip[7:0];
            6'd34:   hdr_byte = i_cfg.source_port[15:8];
            6'd35:   hdr_byte = i_cfg.source_port[7:0];
            6'd36:   hdr_byte = i_cfg.dest_port[15:8];
            6'd37:   hdr_byte = i_cfg.dest_port[7:0];
            6'd38:   hdr_byte = udp_len[15:8];
            6'd39:   hdr_byte = udp_len[7:0];
            6'd40:   hdr_byte = udp_ck[15:8];
            6'd41:   hdr_byte = udp_ck[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_idx       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_step <= '0;
                        r_idx  <= '0;
                        if (i_q_desc.too_long) begin
                            r_state <= ST_ERR;
                        end else begin
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == udpb_pkg::SUM_STEPS_LAST) begin
                        r_state <= ST_FOLD1;
                    end
                end
                ST_FOLD1: begin
                    r_state <= ST_FOLD2;
                end
                ST_FOLD2: begin
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    if (out_free) begin
                        r_idx <= r_idx + 1'b1;
                        if (last_byte) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_IDLE: begin
                r_len     <= i_q_desc.len;
                r_ident   <= i_q_desc.ident;
                r_udp_acc <= udpb_pkg::ACC_W'(i_q_desc.sum);
                r_ip_acc  <= udpb_pkg::ACC_W'(udpb_pkg::IP_FIXED_SUM);
            end
            ST_SUM: begin
                r_udp_acc <= r_udp_acc + udpb_pkg::ACC_W'(udp_term);
                r_ip_acc  <= r_ip_acc + udpb_pkg::ACC_W'(ip_term);
            end
            ST_FOLD1, ST_FOLD2: begin
                r_udp_acc <= udpb_pkg::ACC_W'(r_udp_acc[15:0])
                           + udpb_pkg::ACC_W'(r_udp_acc[udpb_pkg::ACC_W-1:16]);
                r_ip_acc  <= udpb_pkg::ACC_W'(r_ip_acc[15:0])
                           + udpb_pkg::ACC_W'(r_ip_acc[udpb_pkg::ACC_W-1:16]);
            end
            ST_SEND: begin
                if (out_free) begin
                    r_header_byte <= hdr_byte;
                    r_run_end     <= last_byte;
                    r_too_long    <= 1'b0;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    r_header_byte <= 8'h00;
                    r_run_end     <= 1'b1;
                    r_too_long    <= 1'b1;
                end
            end
            default: begin
                r_len <= r_len;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_header_byte = r_header_byte;
    assign o_run_end     = r_run_end;
    assign o_too_long    = r_too_long;

endmodule

`default_nettype wire

// ----- rtl/udp_ipv4_header_builder_unit.sv -----
// UDP/IPv4 header builder.
// Payload bytes arrive on the input channel (i_in_valid / o_in_ready), one
// byte per transaction, with i_final_byte marking the last byte of a datagram
// and i_ident carrying the IPv4 identification on that last transaction.
// Bytes are accepted back to back, one per cycle, while the
// descriptor queue between the accumulator and the header sequencer has room.
// For each datagram the output channel (o_out_valid / i_out_ready) delivers
// 42 header bytes in wire order, the last one flagged by o_run_end, or one
// error transaction with o_too_long set when the payload exceeds
// MAX_PAYLOAD_BYTES. The sequencer sums checksum words in state SUM, folds
// them in FOLD1 and FOLD2, then sends the header at one byte per cycle while
// the receiver is ready; it takes the next datagram only once idle, which
// sets the datagram rate when payloads are short. Registers are written
// over the configuration channel (i_cfg_valid / o_cfg_ready, always ready);
// the user must write them only while the block is idle, which it does not
// enforce. Reset restores the register defaults and empties all state. When
// the receiver stalls, the held result stays stable and the four-entry queue
// absorbs further datagrams before o_in_ready drops.
`default_nettype none

module udp_ipv4_header_builder_unit #(
    parameter int MAX_PAYLOAD_BYTES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_final_byte,
    input  wire logic [15:0] i_ident,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_header_byte,
    output logic             o_run_end,
    output logic             o_too_long,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);

    udpb_pkg::t_cfg  r_cfg;
    udpb_pkg::t_desc push_desc;
    udpb_pkg::t_desc pop_desc;

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_mac  <= udpb_pkg::RST_SOURCE_MAC;
            r_cfg.source_ip   <= udpb_pkg::RST_SOURCE_IP;
            r_cfg.dest_ip     <= udpb_pkg::RST_DEST_IP;
            r_cfg.source_port <= udpb_pkg::RST_SOURCE_PORT;
            r_cfg.dest_port   <= udpb_pkg::RST_DEST_PORT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                udpb_pkg::CFG_SOURCE_MAC:  r_cfg.source_mac  <= i_cfg_data;
                udpb_pkg::CFG_SOURCE_IP:   r_cfg.source_ip   <= i_cfg_data[31:0];
                udpb_pkg::CFG_DEST_IP:     r_cfg.dest_ip     <= i_cfg_data[31:0];
                udpb_pkg::CFG_SOURCE_PORT: r_cfg.source_port <= i_cfg_data[15:0];
                udpb_pkg::CFG_DEST_PORT:   r_cfg.dest_port   <= i_cfg_data[15:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    udpb_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (i_in_valid && o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_final_byte   (i_final_byte),
        .i_ident        (i_ident),
        .o_desc         (push_desc),
        .o_push         (push)
    );

    udpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (pop),
        .o_desc  (pop_desc)
    );

    udpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_q_desc      (pop_desc),
        .o_q_pop       (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_header_byte (o_header_byte),
        .o_run_end     (o_run_end),
        .o_too_long    (o_too_long)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int LEN_LIMIT      = 1024;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 65;

    typedef logic [7:0] t_byte_q[$];

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct packed {
        logic [7:0] hbyte;
        logic       run_end;
        logic       too_long;
    } t_header_result;

    function automatic logic [15:0] ones_fold(input int unsigned s);
        int unsigned acc;
        acc = s;
        while (acc[31:16] != 16'h0000) begin
            acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        end
        return acc[15:0];
    endfunction

    class t_scoreboard;
        udpb_pkg::t_cfg cfg;
        logic [26:0]    pair_sum;
        logic [10:0]    byte_count;
        logic [7:0]     held_high;
        t_header_result header_bytes_due[$];
        int             mismatches;

        function new();
            cfg.source_mac  = udpb_pkg::RST_SOURCE_MAC;
            cfg.source_ip   = udpb_pkg::RST_SOURCE_IP;
            cfg.dest_ip     = udpb_pkg::RST_DEST_IP;
            cfg.source_port = udpb_pkg::RST_SOURCE_PORT;
            cfg.dest_port   = udpb_pkg::RST_DEST_PORT;
            pair_sum   = '0;
            byte_count = '0;
            held_high  = '0;
            mismatches = 0;
        endfunction

        function void note_config(logic [2:0] idx, logic [47:0] data);
            case (idx)
                udpb_pkg::CFG_SOURCE_MAC:  cfg.source_mac  = data;
                udpb_pkg::CFG_SOURCE_IP:   cfg.source_ip   = data[31:0];
                udpb_pkg::CFG_DEST_IP:     cfg.dest_ip     = data[31:0];
                udpb_pkg::CFG_SOURCE_PORT: cfg.source_port = data[15:0];
                udpb_pkg::CFG_DEST_PORT:   cfg.dest_port   = data[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return header_bytes_due.size();
        endfunction

        function void accept_payload(logic [7:0] b, logic fin, logic [15:0] id);
            logic [15:0]    udp_len;
            logic [15:0]    tot_len;
            logic [15:0]    udp_ck;
            logic [15:0]    ip_ck;
            logic [335:0]   hdr;
            int unsigned    acc;
            t_header_result r;
            if (byte_count < LEN_LIMIT) begin
                if (!byte_count[0]) begin
                    held_high = b;
                    if (fin) begin
                        pair_sum = pair_sum + 27'({b, 8'h00});
                    end
                end else begin
                    pair_sum = pair_sum + 27'({held_high, b});
                end
                byte_count = byte_count + 1'b1;
            end else begin
                byte_count = 11'(LEN_LIMIT + 1);
            end
            if (!fin) begin
                return;
            end
            if (byte_count > LEN_LIMIT) begin
                r.hbyte    = 8'h00;
                r.run_end  = 1'b1;
                r.too_long = 1'b1;
                header_bytes_due.push_back(r);
            end else begin
                udp_len = udpb_pkg::UDP_HDR_LEN + 16'(byte_count);
                tot_len = udpb_pkg::IP_UDP_HDR_LEN + 16'(byte_count);
                acc = 32'(pair_sum) + 32'(cfg.source_ip[31:16]) + 32'(cfg.source_ip[15:0])
                    + 32'(cfg.dest_ip[31:16]) + 32'(cfg.dest_ip[15:0])
                    + 32'(udpb_pkg::IP_PROTO_UDP) + 32'(udp_len)
                    + 32'(cfg.source_port) + 32'(cfg.dest_port) + 32'(udp_len);
                udp_ck = ~ones_fold(acc);
                if (udp_ck == 16'h0000) begin
                    udp_ck = udpb_pkg::CSUM_ALL_ONES;
                end
                acc = 32'({udpb_pkg::IP_VER_IHL, 8'h00}) + 32'(tot_len) + 32'(id)
                    + 32'({udpb_pkg::IP_TTL, udpb_pkg::IP_PROTO_UDP})
                    + 32'(cfg.source_ip[31:16]) + 32'(cfg.source_ip[15:0])
                    + 32'(cfg.dest_ip[31:16]) + 32'(cfg.dest_ip[15:0]);
                ip_ck = ~ones_fold(acc);
                hdr = {{6{udpb_pkg::BCAST_BYTE}}, cfg.source_mac, udpb_pkg::ETHERTYPE_IPV4,
                       udpb_pkg::IP_VER_IHL, 8'h00, tot_len, id, 16'h0000,
                       udpb_pkg::IP_TTL, udpb_pkg::IP_PROTO_UDP, ip_ck,
                       cfg.source_ip, cfg.dest_ip, cfg.source_port, cfg.dest_port,
                       udp_len, udp_ck};
                for (int i = 0; i < udpb_pkg::HDR_BYTES; i++) begin
                    r.hbyte    = hdr[335 - 8 * i -: 8];
                    r.run_end  = (i == udpb_pkg::HDR_BYTES - 1);
                    r.too_long = 1'b0;
                    header_bytes_due.push_back(r);
                end
            end
            pair_sum   = '0;
            byte_count = '0;
            held_high  = '0;
        endfunction

        function void check_header_byte(logic [7:0] hb, logic re, logic tl);
            t_header_result want;
            if (header_bytes_due.size() == 0) begin
                $error("unexpected transaction: header_byte %02h run_end %0b too_long %0b",
                       hb, re, tl);
                mismatches++;
                return;
            end
            want = header_bytes_due.pop_front();
            if (hb !== want.hbyte) begin
                $error("header_byte: expected %02h, actual %02h", want.hbyte, hb);
                mismatches++;
            end
            if (re !== want.run_end) begin
                $error("run_end: expected %0b, actual %0b", want.run_end, re);
                mismatches++;
            end
            if (tl !== want.too_long) begin
                $error("too_long: expected %0b, actual %0b", want.too_long, tl);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_payload_byte = '0;
    logic        i_final_byte   = 1'b0;
    logic [15:0] i_ident        = '0;
    logic        i_out_ready    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [2:0]  i_cfg_index    = '0;
    logic [47:0] i_cfg_data     = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_header_byte;
    logic        o_run_end;
    logic        o_too_long;
    logic        o_cfg_ready;

    t_scoreboard predictor = new();

    int items_sent     = 0;
    int tx_fast_left   = 0;
    int rx_fast_left   = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles   = 0;

    udp_ipv4_header_builder_unit #(
        .MAX_PAYLOAD_BYTES(LEN_LIMIT)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_final_byte   (i_final_byte),
        .i_ident        (i_ident),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_header_byte  (o_header_byte),
        .o_run_end      (o_run_end),
        .o_too_long     (o_too_long),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_wait(inout int fast_left);
        if (fast_left > 0) begin
            fast_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            fast_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic t_byte_q make_payload(input int len, input t_fill fill);
        t_byte_q p;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: p.push_back(8'h00);
                FILL_ONES: p.push_back(8'hFF);
                default:   p.push_back(8'($urandom));
            endcase
        end
        return p;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        predictor.note_config(idx, data);
    endtask

    task automatic configure(input logic [47:0] mac, input logic [31:0] sip,
                             input logic [31:0] dip, input logic [15:0] sport,
                             input logic [15:0] dport);
        cfg_write(udpb_pkg::CFG_SOURCE_MAC, mac);
        cfg_write(udpb_pkg::CFG_SOURCE_IP, {16'($urandom), sip});
        cfg_write(udpb_pkg::CFG_DEST_IP, {16'($urandom), dip});
        cfg_write(udpb_pkg::CFG_SOURCE_PORT, {32'($urandom), sport});
        cfg_write(udpb_pkg::CFG_DEST_PORT + 3'($urandom_range(1, 3)),
                  {16'($urandom), 32'($urandom)});
        cfg_write(udpb_pkg::CFG_DEST_PORT, {32'($urandom), dport});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure_random();
        configure({16'($urandom), 32'($urandom)}, $urandom, $urandom,
                  16'($urandom), 16'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic [15:0] id);
        int gap;
        gap = pick_wait(tx_fast_left);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_payload_byte <= b;
        i_final_byte   <= fin;
        i_ident        <= id;
        do @(posedge i_clk); while (!o_in_ready);
        predictor.accept_payload(b, fin, id);
        items_sent++;
    endtask

    task automatic send_datagram(input t_byte_q p, input logic [15:0] id);
        for (int i = 0; i < p.size(); i++) begin
            if (i == p.size() - 1) begin
                send_byte(p[i], 1'b1, id);
            end else begin
                send_byte(p[i], 1'b0, 16'($urandom));
            end
        end
    endtask

    // A two-byte payload chosen so that the ones'-complement sum comes out all ones,
    // which makes the computed UDP checksum zero.
    task automatic send_zero_checksum_datagram();
        int unsigned part;
        logic [15:0] w;
        t_byte_q     p;
        part = 32'(predictor.cfg.source_ip[31:16]) + 32'(predictor.cfg.source_ip[15:0])
             + 32'(predictor.cfg.dest_ip[31:16]) + 32'(predictor.cfg.dest_ip[15:0])
             + 32'(udpb_pkg::IP_PROTO_UDP) + 32'(predictor.cfg.source_port)
             + 32'(predictor.cfg.dest_port)
             + 32'(16'd2 * (udpb_pkg::UDP_HDR_LEN + 16'd2));
        w = ~ones_fold(part);
        p.push_back(w[15:8]);
        p.push_back(w[7:0]);
        send_datagram(p, 16'($urandom));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (predictor.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = pick_wait(rx_fast_left);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            predictor.check_header_byte(o_header_byte, o_run_end, o_too_long);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : stimulus
        int target;
        int sel;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_datagram(make_payload(1, FILL_ONES), 16'h0000);
        send_datagram(make_payload(2, FILL_ZERO), 16'hFFFF);
        send_datagram(make_payload(3, FILL_RANDOM), 16'($urandom));
        settle();
        configure('0, '0, '0, '0, '0);
        send_datagram(make_payload(1, FILL_ZERO), 16'h0000);
        send_zero_checksum_datagram();
        settle();
        configure('1, '1, '1, '1, '1);
        send_datagram(make_payload(4, FILL_ONES), 16'hFFFF);
        send_datagram(make_payload(5, FILL_RANDOM), 16'($urandom));
        send_zero_checksum_datagram();
        settle();
        configure_random();
        send_zero_checksum_datagram();
        send_datagram(make_payload(3, FILL_RANDOM), 16'($urandom));
        settle();

        // Stall the result side for a long stretch while datagrams keep coming,
        // so the descriptor queue fills and the input side backs up.
        rx_hold_cycles = HOLD_CYCLES;
        tx_fast_left = 1000000;
        repeat (12) begin
            send_datagram(make_payload($urandom_range(1, 3), FILL_RANDOM), 16'($urandom));
        end
        tx_fast_left = 0;
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            configure_random();
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                sel = $urandom_range(0, 19);
                if (sel < 14) begin
                    len = $urandom_range(1, 8);
                end else if (sel < 19) begin
                    len = $urandom_range(9, 40);
                end else begin
                    len = $urandom_range(41, 120);
                end
                send_datagram(make_payload(len, FILL_RANDOM), 16'($urandom));
            end
            settle();
        end

        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
